[rtl/spq_pkg.sv]
// shared types and constants of the sorted priority queue
// used by sorted_priority_queue, no dependencies
`default_nettype none

package spq_pkg;

  // process id width is fixed by the entry format
  localparam int unsigned PROCESS_BITS = 16;

  // configuration port geometry
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  // word index of the order mode register
  localparam logic [0:0] REG_ORDER_MODE = 1'b0;

  // command codes of an input word
  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_ENQ_RD   = 3'd1,
    ST_ENQ_CMP  = 3'd2,
    ST_ENQ_PUT  = 3'd3,
    ST_HEAD_RD  = 3'd4,
    ST_HEAD_CAP = 3'd5,
    ST_DEQ_MV   = 3'd6,
    ST_FIN      = 3'd7
  } state_e;

endpackage

`default_nettype wire

[rtl/sorted_priority_queue.sv]
// Sorted priority queue of up to QUEUE_DEPTH entries, head kept at slot 0 of
// a single-port-write, registered-read entry memory. One word is handled at a
// time through one shared key comparator. A peek reads and captures the head, a
// dequeue also shifts the remaining entries one slot toward the head. An enqueue
// walks from the tail, moving one entry per cycle: each stored entry that the
// new one passes moves one slot down, then the new entry is written behind the
// first entry it does not pass, or at slot 0. Into an empty queue it goes to slot 0.
// Enqueue into a full queue, dequeue or peek on an empty one and an unused
// command go straight to the final state. The sequencer waits in its final
// state while the output register still holds an untaken result. A new word
// is taken once the sequencer is back in idle, even if the last result still
// sits in the output register. order_mode (APB word 0) picks whether the
// smaller or the larger priority is served first.
// depends on spq_pkg, spq_ram, spq_cmp
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH   = 64,
  parameter int unsigned PRIORITY_BITS = 32,
  parameter int unsigned HANDLE_BITS   = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input words
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          cmd_i,
  input  wire logic [PRIORITY_BITS-1:0]            priority_in_i,
  input  wire logic [spq_pkg::PROCESS_BITS-1:0]    process_in_i,
  input  wire logic [HANDLE_BITS-1:0]              handle_in_i,
  // result words
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     found_o,
  output logic [HANDLE_BITS-1:0]                   handle_out_o,
  output logic [PRIORITY_BITS-1:0]                 priority_out_o,
  output logic [spq_pkg::PROCESS_BITS-1:0]         process_out_o,
  output logic                                     now_empty_o,
  output logic [1:0]                               status_o,
  // configuration
  input  wire logic                                psel_i,
  input  wire logic                                penable_i,
  input  wire logic                                pwrite_i,
  input  wire logic [spq_pkg::APB_ADDR_BITS-1:0]   paddr_i,
  input  wire logic [spq_pkg::APB_DATA_BITS-1:0]   pwdata_i,
  output logic      [spq_pkg::APB_DATA_BITS-1:0]   prdata_o,
  output logic                                     pready_o
);

  localparam int unsigned QW = spq_pkg::PROCESS_BITS;
  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = PRIORITY_BITS + QW + HANDLE_BITS;

  spq_pkg::state_e state_q, state_d;

  logic [1:0]               cmd_q, cmd_d;
  logic [PRIORITY_BITS-1:0] new_prio_q, new_prio_d;
  logic [QW-1:0]            new_proc_q, new_proc_d;
  logic [HANDLE_BITS-1:0]   new_hand_q, new_hand_d;
  logic [IW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            count_q, count_d;
  logic                     order_q;

  // working copy of the result
  logic                     hd_found_q, hd_found_d;
  logic [PRIORITY_BITS-1:0] hd_prio_q, hd_prio_d;
  logic [QW-1:0]            hd_proc_q, hd_proc_d;
  logic [HANDLE_BITS-1:0]   hd_hand_q, hd_hand_d;
  logic [1:0]               hd_status_q, hd_status_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic                     out_found_q, out_found_d;
  logic [PRIORITY_BITS-1:0] out_prio_q, out_prio_d;
  logic [QW-1:0]            out_proc_q, out_proc_d;
  logic [HANDLE_BITS-1:0]   out_hand_q, out_hand_d;
  logic                     out_empty_q, out_empty_d;
  logic [1:0]               out_status_q, out_status_d;

  // memory and comparator hookup
  logic                     wr_en;
  logic [IW-1:0]            wr_addr;
  logic [EW-1:0]            wr_data;
  logic                     rd_en;
  logic [IW-1:0]            rd_addr;
  logic [EW-1:0]            rd_data;
  logic [PRIORITY_BITS-1:0] slot_prio;
  logic [QW-1:0]            slot_proc;
  logic [HANDLE_BITS-1:0]   slot_hand;
  logic                     new_first;

  logic                     full;
  logic                     empty;
  logic                     idx_last;
  logic                     out_free;
  logic                     cfg_wr;
  logic [EW-1:0]            new_entry;

  assign full      = count_q == CW'(QUEUE_DEPTH);
  assign empty     = count_q == '0;
  assign idx_last  = CW'(idx_q) == (count_q - CW'(1));
  assign out_free  = !out_valid_q || out_ready_i;
  assign new_entry = {new_prio_q, new_proc_q, new_hand_q};
  assign {slot_prio, slot_proc, slot_hand} = rd_data;

  spq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW),
    .AW    (IW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  spq_cmp #(
    .PW (PRIORITY_BITS),
    .QW (QW)
  ) u_cmp (
    .order_mode_i (order_q),
    .new_prio_i   (new_prio_q),
    .new_proc_i   (new_proc_q),
    .slot_prio_i  (slot_prio),
    .slot_proc_i  (slot_proc),
    .before_o     (new_first)
  );

  // configuration port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i
                    && (paddr_i[spq_pkg::APB_ADDR_BITS-1:2] == spq_pkg::REG_ORDER_MODE);

  always_comb begin
    prdata_o = '0;
    if (paddr_i[spq_pkg::APB_ADDR_BITS-1:2] == spq_pkg::REG_ORDER_MODE) begin
      prdata_o[0] = order_q;
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            spq_pkg::CMD_ENQ: begin
              if (full) begin
                state_d = spq_pkg::ST_FIN;
              end else if (empty) begin
                state_d = spq_pkg::ST_ENQ_PUT;
              end else begin
                state_d = spq_pkg::ST_ENQ_RD;
              end
            end
            spq_pkg::CMD_DEQ, spq_pkg::CMD_PEEK: begin
              state_d = empty ? spq_pkg::ST_FIN : spq_pkg::ST_HEAD_RD;
            end
            default: state_d = spq_pkg::ST_FIN;
          endcase
        end
      end
      spq_pkg::ST_ENQ_RD: state_d = spq_pkg::ST_ENQ_CMP;
      spq_pkg::ST_ENQ_CMP: begin
        if (!new_first) begin
          state_d = spq_pkg::ST_FIN;
        end else if (idx_q == '0) begin
          state_d = spq_pkg::ST_ENQ_PUT;
        end
      end
      spq_pkg::ST_ENQ_PUT: state_d = spq_pkg::ST_FIN;
      spq_pkg::ST_HEAD_RD: state_d = spq_pkg::ST_HEAD_CAP;
      spq_pkg::ST_HEAD_CAP: begin
        if (cmd_q == spq_pkg::CMD_DEQ && count_q > CW'(1)) begin
          state_d = spq_pkg::ST_DEQ_MV;
        end else begin
          state_d = spq_pkg::ST_FIN;
        end
      end
      spq_pkg::ST_DEQ_MV: begin
        if (idx_last) begin
          state_d = spq_pkg::ST_FIN;
        end
      end
      spq_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = spq_pkg::ST_IDLE;
        end
      end
      default: state_d = spq_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath
  always_comb begin
    cmd_d        = cmd_q;
    new_prio_d   = new_prio_q;
    new_proc_d   = new_proc_q;
    new_hand_d   = new_hand_q;
    idx_d        = idx_q;
    count_d      = count_q;
    hd_found_d   = hd_found_q;
    hd_prio_d    = hd_prio_q;
    hd_proc_d    = hd_proc_q;
    hd_hand_d    = hd_hand_q;
    hd_status_d  = hd_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_found_d  = out_found_q;
    out_prio_d   = out_prio_q;
    out_proc_d   = out_proc_q;
    out_hand_d   = out_hand_q;
    out_empty_d  = out_empty_q;
    out_status_d = out_status_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = new_entry;
    rd_en        = 1'b0;
    rd_addr      = idx_q;
    in_ready_o   = 1'b0;

    case (state_q)
      spq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d       = cmd_i;
          new_prio_d  = priority_in_i;
          new_proc_d  = process_in_i;
          new_hand_d  = handle_in_i;
          hd_found_d  = 1'b0;
          hd_prio_d   = '0;
          hd_proc_d   = '0;
          hd_hand_d   = '0;
          hd_status_d = spq_pkg::STATUS_OK;
          idx_d       = IW'(count_q - CW'(1));
          case (cmd_i)
            spq_pkg::CMD_ENQ: begin
              if (full) begin
                hd_status_d = spq_pkg::STATUS_FULL;
              end else if (empty) begin
                idx_d = '0;
              end
            end
            spq_pkg::CMD_DEQ, spq_pkg::CMD_PEEK: begin
              if (empty) begin
                hd_status_d = spq_pkg::STATUS_EMPTY;
              end
            end
            default: hd_status_d = spq_pkg::STATUS_OK;
          endcase
        end
      end
      // read the tail slot
      spq_pkg::ST_ENQ_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_q;
      end
      // move the slot one place down or drop the new entry behind it
      spq_pkg::ST_ENQ_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx_q + IW'(1);
        if (new_first) begin
          wr_data = rd_data;
          if (idx_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = idx_q - IW'(1);
            idx_d   = idx_q - IW'(1);
          end
        end else begin
          wr_data = new_entry;
          count_d = count_q + CW'(1);
        end
      end
      spq_pkg::ST_ENQ_PUT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = new_entry;
        count_d = count_q + CW'(1);
      end
      spq_pkg::ST_HEAD_RD: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      // capture the head, start the shift for a dequeue
      spq_pkg::ST_HEAD_CAP: begin
        hd_found_d = 1'b1;
        hd_prio_d  = slot_prio;
        hd_proc_d  = slot_proc;
        hd_hand_d  = slot_hand;
        if (cmd_q == spq_pkg::CMD_DEQ) begin
          if (count_q > CW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = IW'(1);
            idx_d   = IW'(1);
          end else begin
            count_d = count_q - CW'(1);
          end
        end
      end
      // move one slot toward the head per cycle
      spq_pkg::ST_DEQ_MV: begin
        wr_en   = 1'b1;
        wr_addr = idx_q - IW'(1);
        wr_data = rd_data;
        if (idx_last) begin
          count_d = count_q - CW'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q + IW'(1);
          idx_d   = idx_q + IW'(1);
        end
      end
      // hand the result to the output register
      spq_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_found_d  = hd_found_q;
          out_prio_d   = hd_prio_q;
          out_proc_d   = hd_proc_q;
          out_hand_d   = hd_hand_q;
          out_status_d = hd_status_q;
          out_empty_d  = empty;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::ST_IDLE;
      count_q     <= '0;
      order_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        order_q <= pwdata_i[0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    new_prio_q   <= new_prio_d;
    new_proc_q   <= new_proc_d;
    new_hand_q   <= new_hand_d;
    idx_q        <= idx_d;
    hd_found_q   <= hd_found_d;
    hd_prio_q    <= hd_prio_d;
    hd_proc_q    <= hd_proc_d;
    hd_hand_q    <= hd_hand_d;
    hd_status_q  <= hd_status_d;
    out_found_q  <= out_found_d;
    out_prio_q   <= out_prio_d;
    out_proc_q   <= out_proc_d;
    out_hand_q   <= out_hand_d;
    out_empty_q  <= out_empty_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign handle_out_o   = out_hand_q;
  assign priority_out_o = out_prio_q;
  assign process_out_o  = out_proc_q;
  assign now_empty_o    = out_empty_q;
  assign status_o       = out_status_q;

`ifndef SYNTHESIS
  // fill level never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("fill level above capacity");

  // fill level moves by at most one entry per cycle
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CW'(1)
              || count_q + CW'(1) == $past(count_q)))
    else $error("fill level jumped");

  // memory writes stay within the occupied slots plus the new one
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (CW'(wr_addr) <= count_q))
    else $error("write beyond fill level");

  // a returned entry always carries ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (status_o == spq_pkg::STATUS_OK))
    else $error("found entry with error status");
`endif

endmodule

`default_nettype wire

[rtl/spq_ram.sv]
// entry store of the queue: one write port, one registered read port
// no package dependencies
`default_nettype none

module spq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/spq_cmp.sv]
// shared key comparator: is the new entry served strictly before a stored one
// no package dependencies
`default_nettype none

module spq_cmp #(
  parameter int unsigned PW = 32,
  parameter int unsigned QW = 16
) (
  input  wire logic          order_mode_i,
  input  wire logic [PW-1:0] new_prio_i,
  input  wire logic [QW-1:0] new_proc_i,
  input  wire logic [PW-1:0] slot_prio_i,
  input  wire logic [QW-1:0] slot_proc_i,
  output logic               before_o
);

  logic prio_lt;
  logic prio_gt;

  assign prio_lt = new_prio_i < slot_prio_i;
  assign prio_gt = new_prio_i > slot_prio_i;

  // priority decides first, higher process id breaks ties
  always_comb begin
    if (prio_lt || prio_gt) begin
      before_o = order_mode_i ? prio_gt : prio_lt;
    end else begin
      before_o = new_proc_i > slot_proc_i;
    end
  end

endmodule

`default_nettype wire
